FILE: hdl/damped_spring_velocity_update_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the damped spring velocity update block
// Shared property templates, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef DAMPED_SPRING_VELOCITY_UPDATE_DEFINES_SVH
`define DAMPED_SPRING_VELOCITY_UPDATE_DEFINES_SVH

// Same-cycle implication
`define DSV_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DSV_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dsv_pkg.sv
// ----------------------------------------------------------------------------
// dsv_pkg
// Types, constants and helpers shared by the spring velocity update pipeline.
// ----------------------------------------------------------------------------
package dsv_pkg;

  // Fixed widths of the datapath
  localparam int ROOT_W      = 34;
  localparam int SQRT_STEPS  = 34;
  localparam int Q_W         = 29;
  localparam int DIV_STEPS   = 29;
  localparam int U_FRAC      = 28;
  localparam int FORCE_STAGES = 13;
  localparam int ADDR_W      = 5;

  localparam logic [Q_W-1:0] UNIT_ONE = 29'h1000_0000;

  // Register indexes
  localparam logic [2:0] REG_STIFFNESS = 3'd0;
  localparam logic [2:0] REG_DAMPING   = 3'd1;
  localparam logic [2:0] REG_REST_LEN  = 3'd2;
  localparam logic [2:0] REG_MIN_LEN   = 3'd3;
  localparam logic [2:0] REG_MAX_LEN   = 3'd4;
  localparam logic [2:0] REG_TIMESTEP  = 3'd5;
  localparam logic [2:0] REG_HAS_A     = 3'd6;
  localparam logic [2:0] REG_HAS_B     = 3'd7;

  // Reset values
  localparam logic [30:0] RST_REST_LEN = 31'd65536;
  localparam logic [30:0] RST_MAX_LEN  = 31'd131072;
  localparam logic [16:0] RST_TIMESTEP = 17'd1049;

  typedef struct packed {
    logic [31:0] pos_a_x;
    logic [31:0] pos_a_y;
    logic [31:0] pos_a_z;
    logic [31:0] pos_b_x;
    logic [31:0] pos_b_y;
    logic [31:0] pos_b_z;
    logic [31:0] vel_a_x;
    logic [31:0] vel_a_y;
    logic [31:0] vel_a_z;
    logic [31:0] vel_b_x;
    logic [31:0] vel_b_y;
    logic [31:0] vel_b_z;
  } dsv_in_t;

  typedef struct packed {
    logic [31:0] new_vel_a_x;
    logic [31:0] new_vel_a_y;
    logic [31:0] new_vel_a_z;
    logic [31:0] new_vel_b_x;
    logic [31:0] new_vel_b_y;
    logic [31:0] new_vel_b_z;
    logic        skipped;
  } dsv_out_t;

  typedef struct packed {
    logic [30:0] stiffness;
    logic [30:0] damping_coeff;
    logic [30:0] rest_length;
    logic [30:0] min_length;
    logic [30:0] max_length;
    logic [16:0] timestep;
    logic        has_body_a;
    logic        has_body_b;
  } cfg_t;

  // Separation and velocities carried along the distance pipeline
  typedef struct packed {
    logic [2:0][32:0] d;
    logic [2:0][31:0] va;
    logic [2:0][31:0] vb;
  } carry_t;

  // Distance pipeline to divider
  typedef struct packed {
    logic              valid;
    logic [ROOT_W-1:0] len;
    carry_t            carry;
  } dist_item_t;

  // Divider to force pipeline: unit direction in sign-magnitude Q1.28
  typedef struct packed {
    logic                valid;
    logic [2:0][Q_W-1:0] q;
    logic [2:0]          neg;
    logic [ROOT_W-1:0]   len;
    logic [2:0][31:0]    va;
    logic [2:0][31:0]    vb;
  } unit_item_t;

  // Magnitude of a 33-bit two's complement value
  function automatic logic [32:0] mag33(logic [32:0] x);
    return x[32] ? 33'(-x) : x;
  endfunction

endpackage

FILE: hdl/dsv_cfg_regs.sv
// ----------------------------------------------------------------------------
// dsv_cfg_regs
// APB register file holding the spring, damping, length, timestep and body-presence settings.
// ----------------------------------------------------------------------------
module dsv_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dsv_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output dsv_pkg::cfg_t             cfg_o
);
  import dsv_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_r;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stiffness     <= '0;
      cfg_r.damping_coeff <= '0;
      cfg_r.rest_length   <= RST_REST_LEN;
      cfg_r.min_length    <= '0;
      cfg_r.max_length    <= RST_MAX_LEN;
      cfg_r.timestep      <= RST_TIMESTEP;
      cfg_r.has_body_a    <= 1'b1;
      cfg_r.has_body_b    <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_STIFFNESS: cfg_r.stiffness     <= pwdata[30:0];
        REG_DAMPING:   cfg_r.damping_coeff <= pwdata[30:0];
        REG_REST_LEN:  cfg_r.rest_length   <= pwdata[30:0];
        REG_MIN_LEN:   cfg_r.min_length    <= pwdata[30:0];
        REG_MAX_LEN:   cfg_r.max_length    <= pwdata[30:0];
        REG_TIMESTEP:  cfg_r.timestep      <= pwdata[16:0];
        REG_HAS_A:     cfg_r.has_body_a    <= pwdata[0];
        REG_HAS_B:     cfg_r.has_body_b    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      REG_STIFFNESS: prdata = {1'b0, cfg_r.stiffness};
      REG_DAMPING:   prdata = {1'b0, cfg_r.damping_coeff};
      REG_REST_LEN:  prdata = {1'b0, cfg_r.rest_length};
      REG_MIN_LEN:   prdata = {1'b0, cfg_r.min_length};
      REG_MAX_LEN:   prdata = {1'b0, cfg_r.max_length};
      REG_TIMESTEP:  prdata = {15'b0, cfg_r.timestep};
      REG_HAS_A:     prdata = {31'b0, cfg_r.has_body_a};
      REG_HAS_B:     prdata = {31'b0, cfg_r.has_body_b};
      default:       prdata = '0;
    endcase
  end

endmodule

FILE: hdl/dsv_dist_pipe.sv
// ----------------------------------------------------------------------------
// dsv_dist_pipe
// Separation vector, squared length and pipelined floor square root.
// ----------------------------------------------------------------------------
module dsv_dist_pipe (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  dsv_pkg::dsv_in_t     in_data,
  output dsv_pkg::dist_item_t  dist_o
);
  import dsv_pkg::*;

  typedef struct packed {
    logic [67:0]       val;
    logic [35:0]       rem;
    logic [ROOT_W-1:0] root;
    carry_t            carry;
  } sqrt_st_t;

  // One radix-4 digit of the restoring square root
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t    o;
    logic [37:0] rsh;
    logic [37:0] trial;
    rsh   = {s.rem, s.val[67:66]};
    trial = {2'b00, s.root, 2'b01};
    o     = s;
    o.val = {s.val[65:0], 2'b00};
    if (rsh >= trial) begin
      o.rem  = 36'(rsh - trial);
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = rsh[35:0];
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  carry_t           in_carry;
  carry_t           s1_carry_r, s2_carry_r, s3_carry_r;
  logic             s1_valid_r, s2_valid_r, s3_valid_r;
  logic [2:0][65:0] s2_sq_r;
  logic [65:0]      s3_sum_r;

  logic [SQRT_STEPS-1:0] sq_v_r;
  sqrt_st_t              sq_src [0:SQRT_STEPS];
  sqrt_st_t              sq_nxt [0:SQRT_STEPS-1];
  sqrt_st_t              sq_r   [0:SQRT_STEPS-1];

  // Form the separation at 33 bits
  always_comb begin
    in_carry.d[0]  = {in_data.pos_b_x[31], in_data.pos_b_x}
                   - {in_data.pos_a_x[31], in_data.pos_a_x};
    in_carry.d[1]  = {in_data.pos_b_y[31], in_data.pos_b_y}
                   - {in_data.pos_a_y[31], in_data.pos_a_y};
    in_carry.d[2]  = {in_data.pos_b_z[31], in_data.pos_b_z}
                   - {in_data.pos_a_z[31], in_data.pos_a_z};
    in_carry.va[0] = in_data.vel_a_x;
    in_carry.va[1] = in_data.vel_a_y;
    in_carry.va[2] = in_data.vel_a_z;
    in_carry.vb[0] = in_data.vel_b_x;
    in_carry.vb[1] = in_data.vel_b_y;
    in_carry.vb[2] = in_data.vel_b_z;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      sq_v_r     <= '0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      sq_v_r     <= {sq_v_r[SQRT_STEPS-2:0], s3_valid_r};
    end
  end

  // Difference, squares, sum
  always_ff @(posedge clk) begin
    if (en) begin
      s1_carry_r <= in_carry;
      s2_carry_r <= s1_carry_r;
      for (int i = 0; i < 3; i++) begin
        s2_sq_r[i] <= {33'b0, mag33(s1_carry_r.d[i])} * {33'b0, mag33(s1_carry_r.d[i])};
      end
      s3_carry_r <= s2_carry_r;
      s3_sum_r   <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
    end
  end

  always_comb begin
    sq_src[0].val   = {2'b00, s3_sum_r};
    sq_src[0].rem   = '0;
    sq_src[0].root  = '0;
    sq_src[0].carry = s3_carry_r;
  end

  // Square root stages, one digit each
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    always_comb sq_nxt[k] = sqrt_step(sq_src[k]);
    always_ff @(posedge clk) begin
      if (en) sq_r[k] <= sq_nxt[k];
    end
    assign sq_src[k+1] = sq_r[k];
  end

  assign dist_o.valid = sq_v_r[SQRT_STEPS-1];
  assign dist_o.len   = sq_src[SQRT_STEPS].root;
  assign dist_o.carry = sq_src[SQRT_STEPS].carry;

endmodule

FILE: hdl/dsv_div_pipe.sv
// ----------------------------------------------------------------------------
// dsv_div_pipe
// Three pipelined restoring dividers forming the unit direction d / dist.
// ----------------------------------------------------------------------------
module dsv_div_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  dsv_pkg::dist_item_t dist_i,
  output dsv_pkg::unit_item_t unit_o
);
  import dsv_pkg::*;

  typedef struct packed {
    logic [2:0][ROOT_W-1:0] rem;
    logic [2:0]             nbit;
    logic [2:0][Q_W-1:0]    q;
    logic [2:0]             neg;
    logic [ROOT_W-1:0]      len;
    logic [2:0][31:0]       va;
    logic [2:0][31:0]       vb;
  } div_st_t;

  // One quotient bit on each axis
  function automatic div_st_t div_step(div_st_t s);
    div_st_t         o;
    logic [ROOT_W:0] r;
    logic            qb;
    o = s;
    for (int i = 0; i < 3; i++) begin
      r  = {s.rem[i], s.nbit[i]};
      qb = (r >= {1'b0, s.len});
      if (qb) r = r - {1'b0, s.len};
      o.rem[i]  = r[ROOT_W-1:0];
      o.q[i]    = {s.q[i][Q_W-2:0], qb};
      o.nbit[i] = 1'b0;
    end
    return o;
  endfunction

  logic [DIV_STEPS-1:0] dv_v_r;
  div_st_t              dv_src [0:DIV_STEPS];
  div_st_t              dv_nxt [0:DIV_STEPS-1];
  div_st_t              dv_r   [0:DIV_STEPS-1];

  // Load |d| * 2^28: the bits above the quotient range are folded in up front
  always_comb begin
    logic [32:0] m;
    for (int i = 0; i < 3; i++) begin
      m                 = mag33(dist_i.carry.d[i]);
      dv_src[0].rem[i]  = {2'b00, m[32:1]};
      dv_src[0].nbit[i] = m[0];
      dv_src[0].q[i]    = '0;
      dv_src[0].neg[i]  = dist_i.carry.d[i][32];
    end
    dv_src[0].len = dist_i.len;
    dv_src[0].va  = dist_i.carry.va;
    dv_src[0].vb  = dist_i.carry.vb;
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r <= '0;
    end else if (en) begin
      dv_v_r <= {dv_v_r[DIV_STEPS-2:0], dist_i.valid};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    always_comb dv_nxt[k] = div_step(dv_src[k]);
    always_ff @(posedge clk) begin
      if (en) dv_r[k] <= dv_nxt[k];
    end
    assign dv_src[k+1] = dv_r[k];
  end

  assign unit_o.valid = dv_v_r[DIV_STEPS-1];
  assign unit_o.q     = dv_src[DIV_STEPS].q;
  assign unit_o.neg   = dv_src[DIV_STEPS].neg;
  assign unit_o.len   = dv_src[DIV_STEPS].len;
  assign unit_o.va    = dv_src[DIV_STEPS].va;
  assign unit_o.vb    = dv_src[DIV_STEPS].vb;

endmodule

FILE: hdl/dsv_force_pipe.sv
// ----------------------------------------------------------------------------
// dsv_force_pipe
// Clamped spring force, axial damping, impulse and saturated velocity update.
// ----------------------------------------------------------------------------
module dsv_force_pipe (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  dsv_pkg::cfg_t       cfg_i,
  input  dsv_pkg::unit_item_t unit_i,
  output logic                out_valid,
  output dsv_pkg::dsv_out_t   out_data
);
  import dsv_pkg::*;

  typedef struct packed {
    logic                skip;
    logic                ha;
    logic                hb;
    logic [2:0][Q_W-1:0] q;
    logic [2:0]          neg;
    logic [2:0][31:0]    va;
    logic [2:0][31:0]    vb;
  } side_t;

  // Clip to the signed 32-bit range
  function automatic logic [31:0] sat55(logic [54:0] v);
    if (!v[54] && (|v[53:31]))      return 32'h7FFF_FFFF;
    else if (v[54] && !(&v[53:31])) return 32'h8000_0000;
    else                            return v[31:0];
  endfunction

  logic [FORCE_STAGES-1:0] v_r;
  side_t                   sd_r [0:FORCE_STAGES-2];
  side_t                   entry;

  logic [35:0]      ext_c;
  logic [2:0][32:0] dvel_c;
  logic [51:0]      force_c;
  logic [2:0][54:0] sum_a_c, sum_b_c;

  logic [31:0]        f1_ext_r;
  logic [2:0][32:0]   f1_dvel_r;
  logic [30:0]        f2_emag_r;
  logic               f2_eneg_r;
  logic [2:0][32:0]   f2_dmag_r;
  logic [2:0]         f2_pneg_r;
  logic [61:0]        f3_sprod_r;
  logic               f3_eneg_r;
  logic [2:0][61:0]   f3_ap_r;
  logic [2:0]         f3_pneg_r;
  logic [45:0]        f4_spring_r;
  logic               f4_eneg_r;
  logic [63:0]        f4_acc_r;
  logic [45:0]        f5_spring_r;
  logic               f5_eneg_r;
  logic [34:0]        f5_axial_r;
  logic               f5_aneg_r;
  logic [45:0]        f6_spring_r;
  logic               f6_eneg_r;
  logic [65:0]        f6_damp_r;
  logic               f6_aneg_r;
  logic [51:0]        f7_force_r;
  logic [50:0]        f8_fmag_r;
  logic               f8_fneg_r;
  logic [51:0]        f9_imp_r;
  logic               f9_ineg_r;
  logic [2:0][54:0]   f10_plo_r, f10_phi_r;
  logic [2:0]         f10_dneg_r;
  logic [2:0][52:0]   f11_dvmag_r;
  logic [2:0]         f11_dneg_r;
  logic [2:0][53:0]   f12_dv_r;
  dsv_out_t           out_r;

  // Entry: extension clamp, relative velocity, side data
  always_comb begin
    logic [35:0] lo_b;
    logic [35:0] hi_b;
    ext_c = {2'b00, unit_i.len} - {5'b0, cfg_i.rest_length};
    lo_b  = {5'b0, cfg_i.min_length} - {5'b0, cfg_i.rest_length};
    hi_b  = {5'b0, cfg_i.max_length} - {5'b0, cfg_i.rest_length};
    if ($signed(ext_c) < $signed(lo_b)) ext_c = lo_b;
    if ($signed(ext_c) > $signed(hi_b)) ext_c = hi_b;
    for (int i = 0; i < 3; i++) begin
      dvel_c[i] = {unit_i.vb[i][31], unit_i.vb[i]} - {unit_i.va[i][31], unit_i.va[i]};
    end
    entry.skip = (unit_i.len == '0);
    entry.ha   = cfg_i.has_body_a;
    entry.hb   = cfg_i.has_body_b;
    entry.q    = unit_i.q;
    entry.neg  = unit_i.neg;
    entry.va   = unit_i.va;
    entry.vb   = unit_i.vb;
  end

  // Total force, damping only with both bodies present
  always_comb begin
    logic [51:0] sp;
    logic [51:0] dterm;
    logic [49:0] dq;
    sp    = f6_eneg_r ? 52'(-{6'b0, f6_spring_r}) : {6'b0, f6_spring_r};
    dq    = f6_damp_r[65:16];
    dterm = '0;
    if (sd_r[5].ha && sd_r[5].hb) begin
      dterm = f6_aneg_r ? 52'(-{2'b0, dq}) : {2'b0, dq};
    end
    force_c = sp + dterm;
  end

  // Final velocity sums
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_a_c[i] = {{23{sd_r[11].va[i][31]}}, sd_r[11].va[i]} + {f12_dv_r[i][53], f12_dv_r[i]};
      sum_b_c[i] = {{23{sd_r[11].vb[i][31]}}, sd_r[11].vb[i]} - {f12_dv_r[i][53], f12_dv_r[i]};
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[FORCE_STAGES-2:0], unit_i.valid};
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= entry;
      for (int k = 1; k < FORCE_STAGES - 1; k++) sd_r[k] <= sd_r[k-1];

      f1_ext_r  <= ext_c[31:0];
      f1_dvel_r <= dvel_c;

      f2_emag_r <= f1_ext_r[31] ? 31'(-f1_ext_r) : f1_ext_r[30:0];
      f2_eneg_r <= f1_ext_r[31];
      for (int i = 0; i < 3; i++) begin
        f2_dmag_r[i] <= mag33(f1_dvel_r[i]);
        f2_pneg_r[i] <= f1_dvel_r[i][32] ^ sd_r[0].neg[i];
      end

      f3_sprod_r <= {31'b0, f2_emag_r} * {31'b0, cfg_i.stiffness};
      f3_eneg_r  <= f2_eneg_r;
      for (int i = 0; i < 3; i++) begin
        f3_ap_r[i] <= {29'b0, f2_dmag_r[i]} * {33'b0, sd_r[1].q[i]};
      end
      f3_pneg_r <= f2_pneg_r;

      f4_spring_r <= f3_sprod_r[61:16];
      f4_eneg_r   <= f3_eneg_r;
      f4_acc_r    <= (f3_pneg_r[0] ? 64'(-{2'b0, f3_ap_r[0]}) : {2'b0, f3_ap_r[0]})
                   + (f3_pneg_r[1] ? 64'(-{2'b0, f3_ap_r[1]}) : {2'b0, f3_ap_r[1]})
                   + (f3_pneg_r[2] ? 64'(-{2'b0, f3_ap_r[2]}) : {2'b0, f3_ap_r[2]});

      f5_spring_r <= f4_spring_r;
      f5_eneg_r   <= f4_eneg_r;
      f5_axial_r  <= f4_acc_r[63] ? 35'((64'(-f4_acc_r)) >> U_FRAC) : f4_acc_r[62:28];
      f5_aneg_r   <= f4_acc_r[63];

      f6_spring_r <= f5_spring_r;
      f6_eneg_r   <= f5_eneg_r;
      f6_damp_r   <= {31'b0, f5_axial_r} * {35'b0, cfg_i.damping_coeff};
      f6_aneg_r   <= f5_aneg_r;

      f7_force_r <= force_c;

      f8_fmag_r <= f7_force_r[51] ? 51'(-f7_force_r) : f7_force_r[50:0];
      f8_fneg_r <= f7_force_r[51];

      f9_imp_r  <= 52'(({17'b0, f8_fmag_r} * {51'b0, cfg_i.timestep}) >> 16);
      f9_ineg_r <= f8_fneg_r;

      for (int i = 0; i < 3; i++) begin
        f10_plo_r[i]  <= {29'b0, f9_imp_r[25:0]} * {26'b0, sd_r[8].q[i]};
        f10_phi_r[i]  <= {29'b0, f9_imp_r[51:26]} * {26'b0, sd_r[8].q[i]};
        f10_dneg_r[i] <= f9_ineg_r ^ sd_r[8].neg[i];
      end

      for (int i = 0; i < 3; i++) begin
        f11_dvmag_r[i] <= 53'(({f10_phi_r[i], 26'b0} + {26'b0, f10_plo_r[i]}) >> U_FRAC);
      end
      f11_dneg_r <= f10_dneg_r;

      for (int i = 0; i < 3; i++) begin
        f12_dv_r[i] <= f11_dneg_r[i] ? 54'(-{1'b0, f11_dvmag_r[i]}) : {1'b0, f11_dvmag_r[i]};
      end

      // Output register: apply to present bodies, pass through on skip
      out_r.new_vel_a_x <= (sd_r[11].ha && !sd_r[11].skip) ? sat55(sum_a_c[0]) : sd_r[11].va[0];
      out_r.new_vel_a_y <= (sd_r[11].ha && !sd_r[11].skip) ? sat55(sum_a_c[1]) : sd_r[11].va[1];
      out_r.new_vel_a_z <= (sd_r[11].ha && !sd_r[11].skip) ? sat55(sum_a_c[2]) : sd_r[11].va[2];
      out_r.new_vel_b_x <= (sd_r[11].hb && !sd_r[11].skip) ? sat55(sum_b_c[0]) : sd_r[11].vb[0];
      out_r.new_vel_b_y <= (sd_r[11].hb && !sd_r[11].skip) ? sat55(sum_b_c[1]) : sd_r[11].vb[1];
      out_r.new_vel_b_z <= (sd_r[11].hb && !sd_r[11].skip) ? sat55(sum_b_c[2]) : sd_r[11].vb[2];
      out_r.skipped     <= sd_r[11].skip;
    end
  end

  assign out_valid = v_r[FORCE_STAGES-1];
  assign out_data  = out_r;

endmodule

FILE: hdl/damped_spring_velocity_update.sv
// ----------------------------------------------------------------------------
// damped_spring_velocity_update
// Damped spring velocity update between two bodies, Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | dsv_in_t, 12 x Q16.16
//  out_    | output    | out_valid/out_stall | dsv_out_t, 6 x Q16.16 + skipped
//  APB     | input     | psel/penable/pready | 8 registers at 4*i
//
//  One transaction enters per cycle while in_stall is low. Pipeline stages: 3 for
//  distance squared, 34 square root digit stages, 29 divider stages, 13 force stages.
//  The square root and the three dividers set the depth, one bit each stage.
//  A held result with out_stall high freezes the whole pipeline and in_stall.
//  rst_n clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`include "damped_spring_velocity_update_defines.svh"

module damped_spring_velocity_update (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  dsv_pkg::dsv_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output dsv_pkg::dsv_out_t          out_data,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dsv_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import dsv_pkg::*;

  cfg_t       cfg;
  dist_item_t dist_item;
  unit_item_t unit_item;
  logic       pipe_en;

  // Hold every stage while the output transaction waits
  assign pipe_en  = !(out_valid && out_stall);
  assign in_stall = !pipe_en;

  dsv_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dsv_dist_pipe u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .dist_o   (dist_item)
  );

  dsv_div_pipe u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (pipe_en),
    .dist_i (dist_item),
    .unit_o (unit_item)
  );

  dsv_force_pipe u_force (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .cfg_i     (cfg),
    .unit_i    (unit_item),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Distance of 33-bit components stays below 2^33
  `DSV_ASSERT_NOW(a_dist_range, dist_item.valid, dist_item.len[ROOT_W-1] == 1'b0, "distance out of range")

  // Unit direction components never exceed one
  `DSV_ASSERT_NOW(a_unit_bound, unit_item.valid && (unit_item.len != '0), (unit_item.q[0] <= UNIT_ONE) && (unit_item.q[1] <= UNIT_ONE) && (unit_item.q[2] <= UNIT_ONE), "unit direction above one")

  // A frozen pipeline keeps its divider output
  `DSV_ASSERT_NEXT(a_freeze, !pipe_en, $stable(unit_item), "pipeline moved while stalled")

endmodule
